FILE: src/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg: shared constants for the C comment stripper
// Byte codes that the stripper treats specially.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ccs_pkg;

  localparam int unsigned CharWidth = 8;

  localparam logic [CharWidth-1:0] ChSlash     = 8'h2F;
  localparam logic [CharWidth-1:0] ChStar      = 8'h2A;
  localparam logic [CharWidth-1:0] ChBackslash = 8'h5C;
  localparam logic [CharWidth-1:0] ChNewline   = 8'h0A;

  // Scanner state carried from one byte to the next
  typedef struct packed {
    logic in_block_comment;
    logic in_line_comment;
    logic slash_pending;
    logic star_pending;
    logic escape_pending;
    logic line_has_text;
    logic prev_line_empty;
  } scan_state_t;

  localparam scan_state_t ScanReset = '{
    in_block_comment: 1'b0,
    in_line_comment:  1'b0,
    slash_pending:    1'b0,
    star_pending:     1'b0,
    escape_pending:   1'b0,
    line_has_text:    1'b0,
    prev_line_empty:  1'b1
  };

endpackage

`default_nettype wire

FILE: src/c_comment_stripper.sv
// ----------------------------------------------------------------------------
// c_comment_stripper: streaming C/C++ comment remover
// Takes newline-terminated source text a byte at a time and passes it on
// with // and /* */ comments removed and blank lines folded.
// ----------------------------------------------------------------------------
// Takes one byte per cycle on the slave stream, while the result register can
// take it, and gives the cleaned text on the master stream, one byte per
// transfer, with tlast set on the final byte produced by each input byte. An
// input byte yields zero, one or two output bytes; the scanner state update
// and result selection are combinational and load a two-entry result register.
// A byte giving one result or none keeps a rate of one input byte per cycle
// while the master stream is ready; a byte giving two results (a held slash
// released by the next byte) holds the input until the first of them has
// been taken, while the second result drains.
`timescale 1ns / 1ps
`default_nettype none

module c_comment_stripper (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output      logic       s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] ch
  output      logic       m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output      logic [7:0] m_axis_tdata_o,   // [7:0] out_char
  output      logic       m_axis_tlast_o
);

  localparam int unsigned W = ccs_pkg::CharWidth;

  ccs_pkg::scan_state_t st_q, st_d;

  // result register: two slots, count of results still to send
  logic [W-1:0] slot0_q, slot0_d;
  logic [W-1:0] slot1_q, slot1_d;
  logic [1:0]   cnt_q, cnt_d;

  logic         in_xfer, out_xfer;
  logic [W-1:0] ch;
  logic [W-1:0] res0, res1;
  logic [1:0]   nres;
  logic         emit_slash;   // held slash released ahead of this byte
  logic         emit_ch;      // this byte passes through
  logic         emit_nl;      // line end emitted

  assign ch       = s_axis_tdata_i;
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;

  assign s_axis_tready_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_axis_tready_i);
  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = slot0_q;
  assign m_axis_tlast_o  = (cnt_q == 2'd1);

  // scanner: next state and which bytes come out
  always_comb begin
    st_d       = st_q;
    emit_slash = 1'b0;
    emit_ch    = 1'b0;
    emit_nl    = 1'b0;
    if (ch == ccs_pkg::ChNewline) begin
      if (st_q.slash_pending) begin
        emit_slash = 1'b1;
      end
      st_d.slash_pending   = 1'b0;
      st_d.escape_pending  = 1'b0;
      st_d.in_line_comment = 1'b0;
      st_d.star_pending    = 1'b0;
      if (st_q.line_has_text || st_q.slash_pending) begin
        emit_nl              = 1'b1;
        st_d.prev_line_empty = 1'b0;
      end else if (!st_q.prev_line_empty) begin
        emit_nl              = 1'b1;
        st_d.prev_line_empty = 1'b1;
      end
      st_d.line_has_text = 1'b0;
    end else if (st_q.escape_pending) begin
      emit_ch             = 1'b1;
      st_d.line_has_text  = 1'b1;
      st_d.escape_pending = 1'b0;
    end else if (st_q.in_line_comment) begin
      // dropped
    end else if (st_q.in_block_comment) begin
      if (st_q.star_pending && (ch == ccs_pkg::ChSlash)) begin
        st_d.in_block_comment = 1'b0;
        st_d.star_pending     = 1'b0;
      end else begin
        st_d.star_pending = (ch == ccs_pkg::ChStar);
      end
    end else begin
      // plain text, possibly behind a held slash
      st_d.slash_pending = 1'b0;
      if (st_q.slash_pending && (ch == ccs_pkg::ChSlash)) begin
        st_d.in_line_comment = 1'b1;
      end else if (st_q.slash_pending && (ch == ccs_pkg::ChStar)) begin
        st_d.in_block_comment = 1'b1;
        st_d.star_pending     = 1'b0;
      end else begin
        if (st_q.slash_pending) begin
          emit_slash         = 1'b1;
          st_d.line_has_text = 1'b1;
        end
        if (ch == ccs_pkg::ChSlash) begin
          st_d.slash_pending = 1'b1;
        end else begin
          emit_ch            = 1'b1;
          st_d.line_has_text = 1'b1;
          if (ch == ccs_pkg::ChBackslash) begin
            st_d.escape_pending = 1'b1;
          end
        end
      end
    end
  end

  // pack the results in emission order
  always_comb begin
    res1 = ch;
    if (emit_slash) begin
      res0 = ccs_pkg::ChSlash;
      res1 = emit_nl ? ccs_pkg::ChNewline : ch;
    end else if (emit_nl) begin
      res0 = ccs_pkg::ChNewline;
    end else begin
      res0 = ch;
    end
    nres = {1'b0, emit_slash} + {1'b0, emit_ch} + {1'b0, emit_nl};
  end

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    cnt_d   = cnt_q;
    if (in_xfer) begin
      slot0_d = res0;
      slot1_d = res1;
      cnt_d   = nres;
    end else if (out_xfer) begin
      slot0_d = slot1_q;
      cnt_d   = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ccs_pkg::ScanReset;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (in_xfer) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result count out of range");

  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !s_axis_tready_o)
    else $error("input taken while both result slots are busy");

  a_drain_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && (cnt_q == 2'd2)) |=> (cnt_q == 2'd1) && (m_axis_tdata_o == $past(slot1_q)))
    else $error("second result lost on drain");

  a_comment_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_q.in_block_comment && st_q.in_line_comment))
    else $error("block and line comment both active");

  a_star_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.star_pending |-> st_q.in_block_comment)
    else $error("star held outside a block comment");

endmodule

`default_nettype wire
